@@ sv/bis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

   // Element and result field widths.
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 7;
   localparam int FUNC_W  = 2;

   // Default number of set entries.
   localparam int DEFAULT_CAPACITY = 64;

   // Operation codes carried on the request tuser.
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   // Packed widths of the stream payloads.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_BITS   = 1 + 1 + 1 + SIZE_W + 1 + VALUE_W + VALUE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Summary of one scan over the occupied entries.
   typedef struct packed {
      logic               found;     // the looked-up value is stored
      logic               has_other; // at least one entry differs from it
      logic [VALUE_W-1:0] lo;        // minimum over the other entries
      logic [VALUE_W-1:0] hi;        // maximum over the other entries
      logic [VALUE_W-1:0] last;      // content of the last occupied entry
   } scan_stat_type;

endpackage

`default_nettype wire

@@ sv/bis_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bis_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bis_scan #(
   parameter int ADDR_W = 6
) (
   input  wire logic                            clock,
   input  wire logic                            start,
   input  wire logic                            rd_valid,
   input  wire logic [ADDR_W-1:0]               rd_idx,
   input  wire logic [bis_pkg::VALUE_W-1:0]     rd_data,
   input  wire logic [bis_pkg::VALUE_W-1:0]     value,
   input  wire logic [ADDR_W-1:0]               last_idx,
   output bis_pkg::scan_stat_type               stat,
   output logic      [ADDR_W-1:0]               slot
);

   import bis_pkg::*;

   scan_stat_type    stat_ff, stat_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;

   // Entries are distinct, so leaving out the one equal to the value
   // gives the extremes of the set with that value removed.
   always_comb begin
      stat_in = stat_ff;
      slot_in = slot_ff;
      if (start) begin
         stat_in.found     = 1'b0;
         stat_in.has_other = 1'b0;
      end else if (rd_valid) begin
         if (rd_data == value) begin
            stat_in.found = 1'b1;
            slot_in       = rd_idx;
         end else if (!stat_ff.has_other) begin
            stat_in.has_other = 1'b1;
            stat_in.lo        = rd_data;
            stat_in.hi        = rd_data;
         end else begin
            if ($signed(rd_data) < $signed(stat_ff.lo)) begin
               stat_in.lo = rd_data;
            end
            if ($signed(stat_ff.hi) < $signed(rd_data)) begin
               stat_in.hi = rd_data;
            end
         end
         if (rd_idx == last_idx) begin
            stat_in.last = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      slot_ff <= slot_in;
   end

   assign stat = stat_ff;
   assign slot = slot_ff;

endmodule

`default_nettype wire

@@ sv/bounded_integer_set_store_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bounded set of distinct signed 32-bit integers.
// Each request transfer on the req_ channel carries an operation on req_tuser
// (insert, remove, or lookup; the unused code acts as a lookup) and a value on
// req_tdata. Each request yields exactly one response transfer on the rsp_
// channel: whether the value was present before, whether the set changed, a
// refused-insert flag for a full set, and the size, empty flag, minimum and
// maximum of the set after the operation (minimum and maximum read 0 when the
// set is empty).
// The entries live in one synchronous RAM. A request passes through these
// steps: accept; the reads of the stored elements through the single RAM
// read port, followed by the arrival of the last read data; the write-back;
// and the load of the response register. The scan is finished before the
// write-back, and the next scan starts after it, so RAM reads and writes
// never overlap on the same entry. If the receiver stalls, the response
// waits in its output register while the next request is accepted and
// scanned; the block then holds in its response stage until the register
// is free. Reset empties the set; the RAM contents are not cleared since
// only occupied entries are ever read.
module bounded_integer_set_store_top #(
   parameter int CAPACITY = bis_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] value
   input  wire logic [bis_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [bis_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] found, [1] changed, [2] full_error, [9:3] size, [10] empty_res,
   // [42:11] min_value, [74:43] max_value, upper bits zero
   output logic      [bis_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import bis_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]    rd_idx_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [RSP_BITS-1:0]  pend_ff, pend_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_BITS-1:0]  rsp_data_ff;

   logic                 req_fire;
   logic                 rd_en;
   logic [VALUE_W-1:0]   rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    last_idx;
   scan_stat_type        stat;
   logic [ADDR_W-1:0]    slot;

   // Write-back decode.
   logic                 is_insert, is_remove, set_full;
   logic                 do_insert, do_remove, full_err, keep_value;
   logic [VALUE_W-1:0]   lo_value, hi_value;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign last_idx   = ADDR_W'(count_ff - CNT_W'(1));

   // Scan reads go out while the read pointer is below the count.
   assign rd_en = (state_ff == ST_SCAN) && (rd_addr_ff < count_ff);

   bis_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   bis_scan #(
      .ADDR_W (ADDR_W)
   ) u_scan (
      .clock    (clock),
      .start    (req_fire),
      .rd_valid (rd_valid_ff),
      .rd_idx   (rd_idx_ff),
      .rd_data  (rd_data),
      .value    (value_ff),
      .last_idx (last_idx),
      .stat     (stat),
      .slot     (slot)
   );

   // Decide the operation outcome from the finished scan.
   always_comb begin
      is_insert = (func_ff == FUNC_INSERT);
      is_remove = (func_ff == FUNC_REMOVE);
      set_full  = (count_ff == CNT_W'(CAPACITY));
      do_insert = is_insert && !stat.found && !set_full;
      do_remove = is_remove && stat.found;
      full_err  = is_insert && !stat.found && set_full;
      // The value belongs to the set afterwards.
      keep_value = (stat.found && !is_remove) || do_insert;

      if (stat.has_other && keep_value) begin
         lo_value = ($signed(value_ff) < $signed(stat.lo)) ? value_ff : stat.lo;
         hi_value = ($signed(stat.hi) < $signed(value_ff)) ? value_ff : stat.hi;
      end else if (stat.has_other) begin
         lo_value = stat.lo;
         hi_value = stat.hi;
      end else if (keep_value) begin
         lo_value = value_ff;
         hi_value = value_ff;
      end else begin
         lo_value = '0;
         hi_value = '0;
      end

      wr_en   = (state_ff == ST_UPDATE) && (do_insert || do_remove);
      wr_addr = do_insert ? count_ff[ADDR_W-1:0] : slot;
      wr_data = do_insert ? value_ff : stat.last;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      rd_valid_in   = 1'b0;
      pend_in       = pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_addr_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_addr_ff < count_ff) begin
               rd_addr_in  = rd_addr_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end else begin
               // The final read data is folded in at this edge.
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (do_insert) begin
               count_in = count_ff + CNT_W'(1);
            end else if (do_remove) begin
               count_in = count_ff - CNT_W'(1);
            end
            pend_in = {hi_value, lo_value,
                       (count_in == '0),
                       SIZE_W'(count_in),
                       full_err,
                       (do_insert || do_remove),
                       stat.found};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_addr_ff[ADDR_W-1:0];
      pend_ff    <= pend_in;
      if (req_fire) begin
         func_ff  <= req_tuser;
         value_ff <= req_tdata[VALUE_W-1:0];
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_data_ff <= pend_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, rsp_data_ff};

   // The element count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // The store is written only at write-back, and only inside the occupied
   // range or at the append position.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UPDATE) && (CNT_W'(wr_addr) <= count_ff))
      else $error("store write outside write-back or beyond the count");

   // An accepted request always starts a scan in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (rd_addr_ff == '0))
      else $error("accepted request did not start a scan");

   // A response is loaded only from the response stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the response stage");

endmodule

`default_nettype wire

@@ test/tb_bounded_integer_set_store_top.sv @@
`timescale 1ns / 1ps

// Block-level bench for the bounded integer set. Requests go in on the req_
// stream, one response per request comes back on the rsp_ stream. A local
// shadow of the set computes every response when its request transfer is
// accepted. The monitor then compares each response transfer, field by
// field, with the oldest pending prediction.
module tb_bounded_integer_set_store_top;

   import bis_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;

   // The fourth operation code has no function of its own; the block treats
   // it as a lookup.
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

   localparam int POOL_SIZE       = 80;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES     = 2 * (CAPACITY + 4) + 20;
   // Longest correct quiet stretch is the receiver hold plus one full scan;
   // the limit sits well above it.
   localparam int WATCHDOG_LIMIT  = 5000;

   // One response as the testbench sees it.
   typedef struct packed {
      logic               found;
      logic               changed;
      logic               full_error;
      logic [SIZE_W-1:0]  size;
      logic               empty_res;
      logic [VALUE_W-1:0] min_value;
      logic [VALUE_W-1:0] max_value;
   } set_result_type;

   // One directed request. Where typed is set, the response fields that
   // follow are the expected ones; otherwise the shadow set predicts.
   typedef struct packed {
      logic [FUNC_W-1:0]  op;
      logic [VALUE_W-1:0] value;
      logic               typed;
      logic               found;
      logic               changed;
      logic               full_error;
      logic [SIZE_W-1:0]  size;
      logic               empty_res;
      logic [VALUE_W-1:0] min_value;
      logic [VALUE_W-1:0] max_value;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 23;

   // The directed sequence walks the set from empty through the value
   // extremes, duplicates, the spare code and absent removes back to empty.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1, 32'h0, 32'h0},
      '{FUNC_REMOVE, 32'h0000_0005, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1, 32'h0, 32'h0},
      '{FUNC_INSERT, VAL_MIN,       1'b1, 1'b0, 1'b1, 1'b0, 7'd1, 1'b0, VAL_MIN, VAL_MIN},
      '{FUNC_INSERT, VAL_MAX,       1'b1, 1'b0, 1'b1, 1'b0, 7'd2, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_INSERT, VAL_MIN,       1'b1, 1'b1, 1'b0, 1'b0, 7'd2, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 7'd3, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 7'd4, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 7'd4, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_SPARE,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 7'd4, 1'b0, VAL_MIN, VAL_MAX},
      '{FUNC_SPARE,  32'h0000_0007, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_LOOKUP, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, VAL_MIN,       1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, VAL_MIN,       1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, VAL_MAX,       1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_INSERT, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 32'h0, 32'h0},
      '{FUNC_REMOVE, 32'h5555_5555, 1'b1, 1'b1, 1'b1, 1'b0, 7'd0, 1'b1, 32'h0, 32'h0},
      '{FUNC_LOOKUP, VAL_MAX,       1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1, 32'h0, 32'h0},
      '{FUNC_INSERT, 32'h0000_0001, 1'b1, 1'b0, 1'b1, 1'b0, 7'd1, 1'b0, 32'h1, 32'h1},
      '{FUNC_REMOVE, 32'h0000_0001, 1'b1, 1'b1, 1'b1, 1'b0, 7'd0, 1'b1, 32'h0, 32'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = FUNC_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bounded_integer_set_store_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the set: the occupied entries in the block's own order,
   // since a remove moves the last entry into the freed slot.
   logic [VALUE_W-1:0] shadow_members [CAPACITY];
   int                 shadow_count = 0;

   set_result_type pending_results [$];

   logic [VALUE_W-1:0] value_pool [POOL_SIZE];
   logic [VALUE_W-1:0] boundary_values [5] = '{VAL_MIN, VAL_MAX, 32'h0, 32'hFFFF_FFFF, 32'h1};

   // Idle percentages, one for the sender and one for the receiver.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit rsp_hold_request = 1'b0;

   int error_count    = 0;
   int rsp_count      = 0;
   int op_count [4]   = '{0, 0, 0, 0};
   int refused_count  = 0;
   int peak_size      = 0;

   // Applies one operation to the shadow set and returns the response the
   // block must give for it.
   function automatic set_result_type apply_set_op(input logic [FUNC_W-1:0] op,
                                                   input logic [VALUE_W-1:0] v);
      set_result_type r;
      int             slot;
      int             i;
      r    = '0;
      slot = -1;
      for (i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_members[i] == v) slot = i;
      end
      r.found = (slot >= 0);
      case (op)
         FUNC_INSERT: begin
            if (!r.found) begin
               if (shadow_count < CAPACITY) begin
                  shadow_members[shadow_count] = v;
                  shadow_count++;
                  r.changed = 1'b1;
               end else begin
                  r.full_error = 1'b1;
               end
            end
         end
         FUNC_REMOVE: begin
            if (r.found) begin
               shadow_members[slot] = shadow_members[shadow_count-1];
               shadow_count--;
               r.changed = 1'b1;
            end
         end
         default: begin
            // A lookup, or the spare code, leaves the set alone.
         end
      endcase
      r.size      = shadow_count[SIZE_W-1:0];
      r.empty_res = (shadow_count == 0);
      if (shadow_count > 0) begin
         r.min_value = shadow_members[0];
         r.max_value = shadow_members[0];
         for (i = 1; i < shadow_count; i++) begin
            if ($signed(shadow_members[i]) < $signed(r.min_value)) r.min_value = shadow_members[i];
            if ($signed(shadow_members[i]) > $signed(r.max_value)) r.max_value = shadow_members[i];
         end
      end
      return r;
   endfunction

   // Mostly values from a small pool so that inserts, removes and lookups
   // hit each other; some extremes and some values from the whole range.
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      if (r < 20) return boundary_values[$urandom_range(0, 4)];
      return value_pool[$urandom_range(0, POOL_SIZE-1)];
   endfunction

   function automatic logic [VALUE_W-1:0] pick_member();
      if (shadow_count == 0) return pick_value();
      return shadow_members[$urandom_range(0, shadow_count-1)];
   endfunction

   // Offers one request, waits for its transfer and records the prediction.
   // A typed expectation, where given, replaces the shadow's prediction; the
   // shadow still takes the operation so that it stays in step.
   task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] v,
                          input bit use_typed = 1'b0,
                          input set_result_type typed_result = '0);
      set_result_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_set_op(op, v);
      pending_results.push_back(use_typed ? typed_result : predicted);
      op_count[op]++;
      if (predicted.full_error) refused_count++;
      if (shadow_count > peak_size) peak_size = shadow_count;
   endtask

   // A random request with content that tends to hit the stored values.
   task automatic send_mixed_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_op(FUNC_INSERT, pick_value());
      end else if (r < 70) begin
         send_op(FUNC_REMOVE, ($urandom_range(0, 9) < 6) ? pick_member() : pick_value());
      end else if (r < 92) begin
         send_op(FUNC_LOOKUP, ($urandom_range(0, 1) == 0) ? pick_member() : pick_value());
      end else begin
         send_op(FUNC_SPARE, ($urandom_range(0, 1) == 0) ? pick_member() : pick_value());
      end
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Receiver. It stalls at random by the current percentage, and on request
   // holds off for a long stretch so that the block backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Response monitor. Every response transfer is unpacked and checked
   // against the oldest pending prediction.
   always @(posedge clock) begin : rsp_monitor
      set_result_type got;
      set_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found      = rsp_tdata[0];
         got.changed    = rsp_tdata[1];
         got.full_error = rsp_tdata[2];
         got.size       = rsp_tdata[9:3];
         got.empty_res  = rsp_tdata[10];
         got.min_value  = rsp_tdata[42:11];
         got.max_value  = rsp_tdata[74:43];
         rsp_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: response transfer with no request pending, actual %h",
                     $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("changed", want.changed, got.changed);
            compare_field("full_error", want.full_error, got.full_error);
            compare_field("size", want.size, got.size);
            compare_field("empty_res", want.empty_res, got.empty_res);
            compare_field("min_value", want.min_value, got.min_value);
            compare_field("max_value", want.max_value, got.max_value);
         end
      end
   end

   // Watchdog. A stretch with no transfer on either side longer than any
   // correct run can produce ends the run.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_bounded_integer_set_store_top: FAIL");
         $finish;
      end
   end

   // Main sequence: reset, the directed rows, then three phases of random
   // traffic with different idling on the two sides.
   initial begin : main_sequence
      int               k;
      int               phase;
      int               saved_pct;
      set_result_type   typed;
      directed_row_type row;

      for (k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      for (k = 0; k < 5; k++) value_pool[k] = boundary_values[k];

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 18;
      rsp_idle_pct = 66;

      for (k = 0; k < DIRECTED_COUNT; k++) begin
         row              = directed_rows[k];
         typed.found      = row.found;
         typed.changed    = row.changed;
         typed.full_error = row.full_error;
         typed.size       = row.size;
         typed.empty_res  = row.empty_res;
         typed.min_value  = row.min_value;
         typed.max_value  = row.max_value;
         send_op(row.op, row.value, row.typed, typed);
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 18;
               rsp_idle_pct = 66;
            end
            1: begin
               req_idle_pct = 66;
               rsp_idle_pct = 18;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         repeat (150) send_mixed_op();

         // Long receiver hold while the sender keeps offering back to back,
         // so that the response register and the scan both fill and the
         // block stops taking requests.
         if (phase == 0) begin
            saved_pct        = req_idle_pct;
            req_idle_pct     = 0;
            rsp_hold_request = 1'b1;
            repeat (10) send_mixed_op();
            req_idle_pct     = saved_pct;
         end

         // Fill the set to capacity, then refused inserts of absent values,
         // inserts of stored values into the full set, lookups, then a remove and two inserts.
         while (shadow_count < CAPACITY) send_op(FUNC_INSERT, $urandom);
         repeat (6) send_op(FUNC_INSERT, $urandom);
         repeat (4) send_op(FUNC_INSERT, pick_member());
         repeat (3) send_op(FUNC_LOOKUP, pick_member());
         send_op(FUNC_REMOVE, pick_member());
         send_op(FUNC_INSERT, pick_value());
         send_op(FUNC_INSERT, $urandom);

         // Drain back to empty, with some removes of absent values mixed in.
         while (shadow_count > 0) begin
            if ($urandom_range(0, 99) < 85) begin
               send_op(FUNC_REMOVE, pick_member());
            end else begin
               send_op(FUNC_REMOVE, pick_value());
            end
         end

         repeat (100) send_mixed_op();

         // The sender pauses here until every response of the phase is in.
         req_tvalid <= 1'b0;
         wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d removes, %0d lookups, %0d spare-code requests.",
               op_count[FUNC_INSERT], op_count[FUNC_REMOVE], op_count[FUNC_LOOKUP],
               op_count[FUNC_SPARE]);
      $display("Checked %0d responses; %0d refused inserts on a full set, peak size %0d.",
               rsp_count, refused_count, peak_size);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_bounded_integer_set_store_top: PASS");
      end else begin
         $display("tb_bounded_integer_set_store_top: FAIL");
      end
      $finish;
   end

endmodule
